[hdl/two_beam_direction_counter_macros.svh]
// Assertion macros for the two-beam direction counter.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef TWO_BEAM_DIRECTION_COUNTER_MACROS_SVH
`define TWO_BEAM_DIRECTION_COUNTER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TBDC_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define TBDC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tbdc_pkg.sv]
// Shared types, constants and next-state functions of the two-beam direction counter.
// No dependencies; used by every module of the block.
package tbdc_pkg;

    localparam int DIST_W = 8;
    localparam int COUNT_W = 8;
    localparam int HOLD_W = 16;
    localparam int CODE_W = 4;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 8'd120;
    localparam logic [HOLD_W-1:0] HOLD_PERIODS_RESET = 16'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // Register indexes of the configuration port.
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_HOLD = 1'b1;

    // Tracker codes as they appear on the result stream.
    localparam logic [CODE_W-1:0] CODE_CLEAR = 4'd0;
    localparam logic [CODE_W-1:0] CODE_R = 4'd1;
    localparam logic [CODE_W-1:0] CODE_HOLDR = 4'd2;
    localparam logic [CODE_W-1:0] CODE_RL = 4'd3;
    localparam logic [CODE_W-1:0] CODE_LONLY = 4'd4;
    localparam logic [CODE_W-1:0] CODE_L = 4'd5;
    localparam logic [CODE_W-1:0] CODE_HOLDL = 4'd6;
    localparam logic [CODE_W-1:0] CODE_LR = 4'd7;
    localparam logic [CODE_W-1:0] CODE_RONLY = 4'd8;

    // Direction machine, one-hot.
    typedef enum logic [8:0] {
        TRK_CLEAR = 9'b000000001,
        TRK_R     = 9'b000000010,
        TRK_HOLDR = 9'b000000100,
        TRK_RL    = 9'b000001000,
        TRK_LONLY = 9'b000010000,
        TRK_L     = 9'b000100000,
        TRK_HOLDL = 9'b001000000,
        TRK_LR    = 9'b010000000,
        TRK_RONLY = 9'b100000000
    } trk_state_t;

    typedef enum logic [2:0] {
        EV_NONE = 3'd0,
        EV_RIN  = 3'd1,
        EV_ROUT = 3'd2,
        EV_LIN  = 3'd3,
        EV_LOUT = 3'd4
    } beam_ev_t;

    typedef enum logic [1:0] {
        DONE_NONE  = 2'd0,
        DONE_ENTRY = 2'd1,
        DONE_EXIT  = 2'd2
    } done_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_threshold;
        logic [HOLD_W-1:0] hold_periods;
    } cfg_t;

    typedef struct packed {
        trk_state_t         tracker;
        logic [COUNT_W-1:0] people_inside;
        logic [HOLD_W-1:0]  hold_elapsed;
    } trk_ctx_t;

    typedef struct packed {
        trk_ctx_t ctx;
        logic     entered;
        logic     exited;
    } step_res_t;

    typedef struct packed {
        trk_state_t tracker;
        done_t      done;
        logic       hold_restart;
    } adv_t;

    // States in which each beam is taken to be blocked.
    function automatic logic right_held(input trk_state_t s);
        return (s == TRK_R) || (s == TRK_RL) || (s == TRK_LR) || (s == TRK_RONLY);
    endfunction

    function automatic logic left_held(input trk_state_t s);
        return (s == TRK_RL) || (s == TRK_LONLY) || (s == TRK_L) || (s == TRK_LR);
    endfunction

    // A held beam that clears gives an out event; a free beam that trips gives an in event.
    function automatic beam_ev_t beam_event(input logic held, input logic tripped,
                                            input beam_ev_t ev_in, input beam_ev_t ev_out);
        beam_ev_t ev;
        if (held)
            ev = tripped ? EV_NONE : ev_out;
        else
            ev = tripped ? ev_in : EV_NONE;
        return ev;
    endfunction

    // One move of the direction machine for one beam event.
    function automatic adv_t advance(input trk_state_t s, input beam_ev_t ev);
        adv_t a;
        a.tracker = s;
        a.done = DONE_NONE;
        a.hold_restart = 1'b0;
        unique case (s)
            TRK_R:
            begin
                if (ev == EV_LIN)
                    a.tracker = TRK_RL;
                else if (ev == EV_ROUT)
                begin
                    a.tracker = TRK_HOLDR;
                    a.hold_restart = 1'b1;
                end
            end
            TRK_HOLDR:
            begin
                if (ev == EV_LIN)
                    a.tracker = TRK_RL;
                else if (ev == EV_RIN)
                    a.tracker = TRK_R;
            end
            TRK_RL:
            begin
                if (ev == EV_ROUT)
                    a.tracker = TRK_LONLY;
                else if (ev == EV_LOUT)
                    a.tracker = TRK_R;
            end
            TRK_LONLY:
            begin
                if (ev == EV_LOUT)
                begin
                    a.tracker = TRK_CLEAR;
                    a.done = DONE_ENTRY;
                end
                else if (ev == EV_RIN)
                    a.tracker = TRK_RL;
            end
            TRK_L:
            begin
                if (ev == EV_RIN)
                    a.tracker = TRK_LR;
                else if (ev == EV_LOUT)
                begin
                    a.tracker = TRK_HOLDL;
                    a.hold_restart = 1'b1;
                end
            end
            TRK_HOLDL:
            begin
                if (ev == EV_RIN)
                    a.tracker = TRK_LR;
                else if (ev == EV_LIN)
                    a.tracker = TRK_L;
            end
            TRK_LR:
            begin
                if (ev == EV_LOUT)
                    a.tracker = TRK_RONLY;
                else if (ev == EV_ROUT)
                    a.tracker = TRK_L;
            end
            TRK_RONLY:
            begin
                if (ev == EV_ROUT)
                begin
                    a.tracker = TRK_CLEAR;
                    a.done = DONE_EXIT;
                end
                else if (ev == EV_LIN)
                    a.tracker = TRK_LR;
            end
            default:
            begin
                // Clear, and any pattern that is not a legal state, behaves as clear.
                if (ev == EV_RIN)
                    a.tracker = TRK_R;
                else if (ev == EV_LIN)
                    a.tracker = TRK_L;
                else
                    a.tracker = TRK_CLEAR;
            end
        endcase
        return a;
    endfunction

    // Occupancy update with saturation at both ends.
    function automatic logic [COUNT_W-1:0] apply_done(input logic [COUNT_W-1:0] n,
                                                      input done_t d);
        logic [COUNT_W-1:0] r;
        r = n;
        if ((d == DONE_ENTRY) && (n != COUNT_MAX))
            r = n + COUNT_W'(1);
        else if ((d == DONE_EXIT) && (n != '0))
            r = n - COUNT_W'(1);
        return r;
    endfunction

    function automatic logic [CODE_W-1:0] trk_code(input trk_state_t s);
        logic [CODE_W-1:0] c;
        unique case (s)
            TRK_R:     c = CODE_R;
            TRK_HOLDR: c = CODE_HOLDR;
            TRK_RL:    c = CODE_RL;
            TRK_LONLY: c = CODE_LONLY;
            TRK_L:     c = CODE_L;
            TRK_HOLDL: c = CODE_HOLDL;
            TRK_LR:    c = CODE_LR;
            TRK_RONLY: c = CODE_RONLY;
            default:   c = CODE_CLEAR;
        endcase
        return c;
    endfunction

endpackage

[hdl/tbdc_regs.sv]
// Configuration registers of the two-beam direction counter behind an APB-style port.
// Depends on tbdc_pkg for the register indexes, reset values and cfg_t.
module tbdc_regs
    import tbdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [DIST_W-1:0] threshold_reg;
    logic [HOLD_W-1:0] hold_periods_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Register writes in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            hold_periods_reg <= HOLD_PERIODS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_THRESHOLD: threshold_reg <= pwdata[DIST_W-1:0];
                REG_HOLD:      hold_periods_reg <= pwdata[HOLD_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Read-back of the selected register.
    always_comb
    begin
        unique case (reg_sel)
            REG_THRESHOLD: prdata = {{(32-DIST_W){1'b0}}, threshold_reg};
            REG_HOLD:      prdata = {{(32-HOLD_W){1'b0}}, hold_periods_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.distance_threshold = threshold_reg;
    assign cfg.hold_periods = hold_periods_reg;

endmodule

[hdl/tbdc_step.sv]
// Next-state logic for one sample: beam events, direction machine, count and hold timer.
// Depends on tbdc_pkg for the state types and the machine functions.
module tbdc_step
    import tbdc_pkg::*;
(
    input  cfg_t              cfg,
    input  trk_ctx_t          ctx,
    input  logic [DIST_W-1:0] distance_right,
    input  logic [DIST_W-1:0] distance_left,
    output step_res_t         res
);

    logic              right_trip;
    logic              left_trip;
    beam_ev_t          ev_right;
    beam_ev_t          ev_left;
    adv_t              adv_right;
    adv_t              adv_left;
    logic [COUNT_W-1:0] people_mid;
    logic [HOLD_W-1:0] hold_base;
    logic [HOLD_W-1:0] hold_ticked;
    logic              in_hold;

    // The right beam moves the machine first, the left beam then sees the updated state.
    always_comb
    begin
        right_trip = distance_right < cfg.distance_threshold;
        left_trip = distance_left < cfg.distance_threshold;
        ev_right = beam_event(right_held(ctx.tracker), right_trip, EV_RIN, EV_ROUT);
        adv_right = advance(ctx.tracker, ev_right);
        ev_left = beam_event(left_held(adv_right.tracker), left_trip, EV_LIN, EV_LOUT);
        adv_left = advance(adv_right.tracker, ev_left);
    end

    // Occupancy follows each completed pass in order. The hold timer restarts on entry
    // to a hold state and saturates at full scale.
    always_comb
    begin
        people_mid = apply_done(ctx.people_inside, adv_right.done);
        res.ctx.people_inside = apply_done(people_mid, adv_left.done);
        res.entered = (adv_right.done == DONE_ENTRY) || (adv_left.done == DONE_ENTRY);
        res.exited = (adv_right.done == DONE_EXIT) || (adv_left.done == DONE_EXIT);

        hold_base = (adv_right.hold_restart || adv_left.hold_restart) ? '0 : ctx.hold_elapsed;
        hold_ticked = (hold_base == HOLD_MAX) ? hold_base : hold_base + HOLD_W'(1);
        in_hold = (adv_left.tracker == TRK_HOLDR) || (adv_left.tracker == TRK_HOLDL);
        res.ctx.hold_elapsed = hold_ticked;
        if (in_hold && (hold_ticked >= cfg.hold_periods))
            res.ctx.tracker = TRK_CLEAR;
        else
            res.ctx.tracker = adv_left.tracker;
    end

endmodule

[hdl/two_beam_direction_counter.sv]
// Two-beam direction counter: an accepted item is held in the input register, and its result
// becomes valid once the item has moved on to the result register.
// Throughput one item per clock if m_tready holds; input and result registers hold one item each.
// The tracker, occupancy and hold timer advance in the cycle an item moves to the result register.
// Asynchronous active-low reset: tracker clear, occupancy 0, timer 0, both stages empty,
// threshold 120 cm, hold periods 10. No clearing pass; items are accepted right after reset.
module two_beam_direction_counter
    import tbdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] distance_right, [15:8] distance_left
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] occupancy, [11:8] tracker_code,
                                   // [12] entered_pulse, [13] exited_pulse, [15:14] zero
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "two_beam_direction_counter_macros.svh"

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [DIST_W-1:0]  in_right_reg;
    logic [DIST_W-1:0]  in_left_reg;
    logic               in_fire;
    logic               step_fire;
    trk_ctx_t           ctx_reg;
    step_res_t          step_res;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_occupancy_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_entered_reg;
    logic               out_exited_reg;

    tbdc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbdc_step u_step (
        .cfg            (cfg),
        .ctx            (ctx_reg),
        .distance_right (in_right_reg),
        .distance_left  (in_left_reg),
        .res            (step_res)
    );

    // Handshake: the held item moves on when the result register is free or being taken.
    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_fire;
    assign in_fire = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_right_reg <= s_tdata[DIST_W-1:0];
            in_left_reg <= s_tdata[2*DIST_W-1:DIST_W];
        end
    end

    // Tracker state, advanced once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.tracker <= TRK_CLEAR;
            ctx_reg.people_inside <= '0;
            ctx_reg.hold_elapsed <= '0;
        end
        else if (step_fire)
            ctx_reg <= step_res.ctx;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_occupancy_reg <= step_res.ctx.people_inside;
            out_code_reg <= trk_code(step_res.ctx.tracker);
            out_entered_reg <= step_res.entered;
            out_exited_reg <= step_res.exited;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {2'b00, out_exited_reg, out_entered_reg, out_code_reg, out_occupancy_reg};

    // An entry and an exit cannot complete in the same sample.
    `TBDC_CHECK(a_one_pass, !(out_valid_reg && out_entered_reg && out_exited_reg), "entry and exit together")
    // A step always leaves a result behind it.
    `TBDC_CHECK_NEXT(a_step_result, step_fire, out_valid_reg, "step without result")
    // An entry below the limit raises the count by one.
    `TBDC_CHECK_NEXT(a_entry_count, step_fire && step_res.entered && (ctx_reg.people_inside != COUNT_MAX), ctx_reg.people_inside == $past(ctx_reg.people_inside) + COUNT_W'(1), "entry did not count")

endmodule
